@@ src/sfq_pkg.sv @@
// Shared types and constants for the searchable FIFO queue.
// Holds command and status codes and the controller/datapath interface structs.
// Depends on nothing.
package sfq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		CMD_PUSH  = 3'd0,
		CMD_POP   = 3'd1,
		CMD_FRONT = 3'd2,
		CMD_FIND  = 3'd3,
		CMD_SWAP  = 3'd4,
		CMD_READ  = 3'd5,
		CMD_CLEAR = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_BAD_POS   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_HEAD,
		RD_POS,
		RD_POSM1,
		RD_SCAN
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_TAIL,
		WR_SWAP_A,
		WR_SWAP_B
	} wr_sel_t;

	typedef enum logic [1:0] {
		UPD_NONE,
		UPD_PUSH,
		UPD_POP,
		UPD_CLEAR
	} upd_t;

	typedef enum logic [1:0] {
		RES_PLAIN,
		RES_DATA,
		RES_FOUND
	} res_kind_t;

	// Controller to datapath.
	typedef struct packed {
		logic      load;
		rd_sel_t   rd_sel;
		wr_sel_t   wr_sel;
		upd_t      upd;
		logic      scan_start;
		logic      tmp_load;
		logic      res_load;
		res_kind_t res_kind;
		status_t   res_status;
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [2:0] cmd;
		logic       full;
		logic       empty;
		logic       swap_bad;
		logic       read_bad;
		logic       find_hit;
		logic       find_miss;
	} dp_status_t;

endpackage

@@ src/searchable_fifo_queue.sv @@
// Top level of the searchable FIFO queue: controller plus datapath.
// Depends on sfq_pkg, sfq_ctrl, sfq_dp (and sfq_ram below it).
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | sink      | in_valid/in_stall   | command, value, position
//  out     | source    | out_valid/out_stall | read_value, found_index, status,
//          |           |                     | entry_count, is_empty
//
// One command is in work at a time. Push, pop, front, read, clear and failed
// commands pass from accept through execute to the done state; swap goes
// through extra states for two reads and two writes on the RAM's one read
// and one write port. Find streams one entry per cycle through the
// registered RAM read until a compare hits or the fill count runs out.
// Reset empties the queue at once, with no clearing pass. A stalled result
// stays in the output register; the next command is still taken and waits
// in its final step until that beat leaves.
module searchable_fifo_queue #(
	parameter int DEPTH      = sfq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = sfq_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [31:0] value,
	input  logic [3:0]  position,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_value,
	output logic [3:0]  found_index,
	output logic [2:0]  status,
	output logic [4:0]  entry_count,
	output logic        is_empty
);
	import sfq_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	sfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sfq_dp #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.command    (command),
		.value      (value),
		.position   (position),
		.read_value (read_value),
		.found_index(found_index),
		.status     (status),
		.entry_count(entry_count),
		.is_empty   (is_empty)
	);

endmodule

@@ src/sfq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the queue entry storage; no package dependency.
module sfq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ src/sfq_ctrl.sv @@
// Controller state machine for the searchable FIFO queue.
// Sequences each command through the datapath; uses sfq_pkg.
module sfq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  sfq_pkg::dp_status_t sts,
	output sfq_pkg::ctrl_cmd_t  cmd
);
	import sfq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SW1,
		S_SW2,
		S_SW3,
		S_FIND,
		S_DONE
	} state_t;

	state_t    state_q, nxt_state;
	status_t   st_q, nxt_st;
	res_kind_t kind_q, nxt_kind;
	logic      out_valid_q;
	logic      out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd            = '0;
		cmd.rd_sel     = RD_NONE;
		cmd.wr_sel     = WR_NONE;
		cmd.upd        = UPD_NONE;
		cmd.res_kind   = kind_q;
		cmd.res_status = st_q;
		nxt_state      = state_q;
		nxt_st         = st_q;
		nxt_kind       = kind_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					nxt_state = S_EXEC;
				end
			end
			S_EXEC: begin
				nxt_st    = ST_OK;
				nxt_kind  = RES_PLAIN;
				nxt_state = S_DONE;
				case (sts.cmd)
					CMD_PUSH: begin
						if (sts.full) begin
							nxt_st = ST_FULL;
						end else begin
							cmd.wr_sel = WR_TAIL;
							cmd.upd    = UPD_PUSH;
						end
					end
					CMD_POP: begin
						if (sts.empty) begin
							nxt_st = ST_EMPTY;
						end else begin
							cmd.rd_sel = RD_HEAD;
							cmd.upd    = UPD_POP;
							nxt_kind   = RES_DATA;
						end
					end
					CMD_FRONT: begin
						if (sts.empty) begin
							nxt_st = ST_EMPTY;
						end else begin
							cmd.rd_sel = RD_HEAD;
							nxt_kind   = RES_DATA;
						end
					end
					CMD_FIND: begin
						cmd.scan_start = 1'b1;
						nxt_state      = S_FIND;
					end
					CMD_SWAP: begin
						if (sts.swap_bad) begin
							nxt_st = ST_BAD_POS;
						end else begin
							cmd.rd_sel = RD_POSM1;
							nxt_state  = S_SW1;
						end
					end
					CMD_READ: begin
						if (sts.read_bad) begin
							nxt_st = ST_BAD_POS;
						end else begin
							cmd.rd_sel = RD_POS;
							nxt_kind   = RES_DATA;
						end
					end
					CMD_CLEAR: begin
						cmd.upd = UPD_CLEAR;
					end
					default: begin
						// The unused code leaves everything as it is.
					end
				endcase
			end
			S_SW1: begin
				cmd.tmp_load = 1'b1;
				cmd.rd_sel   = RD_POS;
				nxt_state    = S_SW2;
			end
			S_SW2: begin
				cmd.wr_sel = WR_SWAP_A;
				nxt_state  = S_SW3;
			end
			S_SW3: begin
				cmd.wr_sel = WR_SWAP_B;
				nxt_state  = S_DONE;
			end
			S_FIND: begin
				priority if (sts.find_hit) begin
					nxt_kind  = RES_FOUND;
					nxt_st    = ST_OK;
					nxt_state = S_DONE;
				end else if (sts.find_miss) begin
					nxt_kind  = RES_PLAIN;
					nxt_st    = ST_NOT_FOUND;
					nxt_state = S_DONE;
				end else begin
					cmd.rd_sel = RD_SCAN;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					nxt_state    = S_IDLE;
				end
			end
			default: begin
				nxt_state = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= ST_OK;
			kind_q      <= RES_PLAIN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= nxt_state;
			st_q    <= nxt_st;
			kind_q  <= nxt_kind;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A result is only written into the output register once it is free.
	a_res_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> out_free)
		else $error("result loaded over an untaken beat");

	// A finished find reports success only after a compare has hit.
	a_found_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND && nxt_state == S_DONE && nxt_kind == RES_FOUND)
		|-> sts.find_hit)
		else $error("find reported success without a match");

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("result beat dropped while stalled");

endmodule

@@ src/sfq_dp.sv @@
// Datapath of the searchable FIFO queue: pointers, entry RAM, scan unit and
// result register. Driven by sfq_ctrl; uses sfq_pkg and sfq_ram.
module sfq_dp #(
	parameter int DEPTH      = sfq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = sfq_pkg::DATA_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sfq_pkg::ctrl_cmd_t  cmd,
	output sfq_pkg::dp_status_t sts,
	input  logic [2:0]          command,
	input  logic [31:0]         value,
	input  logic [3:0]          position,
	output logic [31:0]         read_value,
	output logic [3:0]          found_index,
	output logic [2:0]          status,
	output logic [4:0]          entry_count,
	output logic                is_empty
);
	import sfq_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > 4) ? CW : 4;
	localparam int OW = (CW > 5) ? CW : 5;

	logic [PW-1:0]         head_q;
	logic [CW-1:0]         count_q;
	logic [2:0]            cmd_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [3:0]            pos_q;
	logic [DATA_WIDTH-1:0] tmp_q;
	logic [CW-1:0]         scan_idx_q;
	logic [PW-1:0]         scan_slot_q;
	logic                  cmp_vld_q;
	logic [CW-1:0]         cmp_idx_q;

	logic [31:0] res_read_q;
	logic [3:0]  res_found_q;
	logic [2:0]  res_status_q;
	logic [4:0]  res_count_q;
	logic        res_empty_q;

	logic [63:0]           value_ext;
	logic [63:0]           rd_ext;
	logic [XW-1:0]         pos_x, posm1_x, cnt_x, cmp_idx_x;
	logic [OW-1:0]         count_x;
	logic [PW-1:0]         pos_slot, posm1_slot, tail_slot;
	logic                  scan_more;
	logic                  ram_wen, ram_ren;
	logic [PW-1:0]         ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

	// Physical slot of a logical offset; correct while base is below DEPTH and off is at most DEPTH.
	function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
		input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(off);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[PW-1:0];
	endfunction

	assign value_ext  = 64'(value);
	assign rd_ext     = 64'(ram_rdata);
	assign pos_x      = XW'(pos_q);
	assign posm1_x    = pos_x - XW'(1);
	assign cnt_x      = XW'(count_q);
	assign cmp_idx_x  = XW'(cmp_idx_q);
	assign count_x    = OW'(count_q);
	assign pos_slot   = wrap_add(head_q, pos_x[CW-1:0]);
	assign posm1_slot = wrap_add(head_q, posm1_x[CW-1:0]);
	assign tail_slot  = wrap_add(head_q, count_q);
	assign scan_more  = (scan_idx_q < count_q);

	always_comb begin
		sts.cmd       = cmd_q;
		sts.full      = (count_q == CW'(DEPTH));
		sts.empty     = (count_q == '0);
		sts.swap_bad  = (pos_x == '0) || (pos_x >= cnt_x);
		sts.read_bad  = (pos_x >= cnt_x);
		sts.find_hit  = cmp_vld_q && (ram_rdata == val_q);
		sts.find_miss = !cmp_vld_q && !scan_more;
	end

	always_comb begin
		ram_ren   = 1'b0;
		ram_raddr = head_q;
		unique case (cmd.rd_sel)
			RD_NONE: begin
				ram_ren = 1'b0;
			end
			RD_HEAD: begin
				ram_ren = 1'b1;
			end
			RD_POS: begin
				ram_ren   = 1'b1;
				ram_raddr = pos_slot;
			end
			RD_POSM1: begin
				ram_ren   = 1'b1;
				ram_raddr = posm1_slot;
			end
			RD_SCAN: begin
				ram_ren   = scan_more;
				ram_raddr = scan_slot_q;
			end
			default: begin
				ram_ren = 1'b0;
			end
		endcase
	end

	always_comb begin
		ram_wen   = 1'b0;
		ram_waddr = tail_slot;
		ram_wdata = val_q;
		unique case (cmd.wr_sel)
			WR_NONE: begin
				ram_wen = 1'b0;
			end
			WR_TAIL: begin
				ram_wen = 1'b1;
			end
			WR_SWAP_A: begin
				// The later entry moves forward; the earlier one waits in tmp_q.
				ram_wen   = 1'b1;
				ram_waddr = posm1_slot;
				ram_wdata = ram_rdata;
			end
			WR_SWAP_B: begin
				ram_wen   = 1'b1;
				ram_waddr = pos_slot;
				ram_wdata = tmp_q;
			end
			default: begin
				ram_wen = 1'b0;
			end
		endcase
	end

	sfq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wen),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_ren),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			count_q   <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			unique case (cmd.upd)
				UPD_NONE: begin
				end
				UPD_PUSH: begin
					count_q <= count_q + CW'(1);
				end
				UPD_POP: begin
					head_q  <= wrap_add(head_q, CW'(1));
					count_q <= count_q - CW'(1);
				end
				UPD_CLEAR: begin
					head_q  <= '0;
					count_q <= '0;
				end
				default: begin
				end
			endcase
			cmp_vld_q <= (cmd.rd_sel == RD_SCAN) && scan_more;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			val_q <= value_ext[DATA_WIDTH-1:0];
			pos_q <= position;
		end
		if (cmd.tmp_load) begin
			tmp_q <= ram_rdata;
		end
		if (cmd.scan_start) begin
			scan_idx_q  <= '0;
			scan_slot_q <= head_q;
		end else if (cmd.rd_sel == RD_SCAN && scan_more) begin
			cmp_idx_q   <= scan_idx_q;
			scan_idx_q  <= scan_idx_q + CW'(1);
			scan_slot_q <= wrap_add(scan_slot_q, CW'(1));
		end
		if (cmd.res_load) begin
			res_read_q   <= (cmd.res_kind == RES_DATA) ? rd_ext[31:0] : 32'd0;
			res_found_q  <= (cmd.res_kind == RES_FOUND) ? cmp_idx_x[3:0] : 4'd0;
			res_status_q <= cmd.res_status;
			res_count_q  <= count_x[4:0];
			res_empty_q  <= (count_q == '0);
		end
	end

	assign read_value  = res_read_q;
	assign found_index = res_found_q;
	assign status      = res_status_q;
	assign entry_count = res_count_q;
	assign is_empty    = res_empty_q;

	// A push is only issued with room left, and it grows the count by one.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd == UPD_PUSH) |-> (count_q < CW'(DEPTH)))
		else $error("push issued on a full queue");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd == UPD_PUSH) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("push did not advance the fill count");

	// A compare hit always names an entry inside the fill count.
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		sts.find_hit |-> (cmp_idx_q < count_q))
		else $error("find hit outside the stored entries");

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for searchable_fifo_queue: directed and random commands.
// It keeps its own model of the queue and compares every result beat with it.
// Depends on sfq_pkg and the searchable_fifo_queue RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sfq_pkg::*;

	localparam int QDEPTH = DEPTH_DEF;
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int ITEM_TARGET = 1650;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] word;
		logic [3:0]  pos;
	} queue_cmd_t;

	typedef struct packed {
		logic [31:0] rd;
		logic [3:0]  idx;
		logic [2:0]  st;
		logic [4:0]  cnt;
		logic        emp;
	} queue_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  command = '0;
	logic [31:0] value = '0;
	logic [3:0]  position = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] read_value;
	logic [3:0]  found_index;
	logic [2:0]  status;
	logic [4:0]  entry_count;
	logic        is_empty;

	// Shadow copy of the queue contents.
	logic [31:0] shadow_slots [QDEPTH];
	logic [3:0]  shadow_head = '0;
	logic [4:0]  shadow_count = '0;

	queue_cmd_t    pending_cmds [$];
	queue_result_t expected_results [$];
	int            errors = 0;
	int            send_gap = 0;
	int            send_calm = 0;
	int            recv_wait = 0;
	int            recv_calm = 0;
	logic          hold_off = 1'b0;

	searchable_fifo_queue DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.value(value),
		.position(position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_value(read_value),
		.found_index(found_index),
		.status(status),
		.entry_count(entry_count),
		.is_empty(is_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic queue_result_t apply_command(logic [2:0] cmd, logic [31:0] word,
			logic [3:0] pos);
		queue_result_t r;
		logic [31:0]   tmp;
		logic [3:0]    slot_a;
		logic [3:0]    slot_b;
		logic          hit;
		r = '0;
		r.st = ST_OK;
		hit = 1'b0;
		case (cmd)
			CMD_PUSH: begin
				if (shadow_count == 5'(QDEPTH)) begin
					r.st = ST_FULL;
				end else begin
					shadow_slots[shadow_head + shadow_count[3:0]] = word;
					shadow_count = shadow_count + 5'd1;
				end
			end
			CMD_POP: begin
				if (shadow_count == 0) begin
					r.st = ST_EMPTY;
				end else begin
					r.rd = shadow_slots[shadow_head];
					shadow_head = shadow_head + 4'd1;
					shadow_count = shadow_count - 5'd1;
				end
			end
			CMD_FRONT: begin
				if (shadow_count == 0)
					r.st = ST_EMPTY;
				else
					r.rd = shadow_slots[shadow_head];
			end
			CMD_FIND: begin
				r.st = ST_NOT_FOUND;
				for (int i = 0; i < int'(shadow_count); i++) begin
					if (!hit && shadow_slots[shadow_head + i[3:0]] == word) begin
						hit = 1'b1;
						r.idx = i[3:0];
						r.st = ST_OK;
					end
				end
			end
			CMD_SWAP: begin
				if (pos == 0 || {1'b0, pos} >= shadow_count) begin
					r.st = ST_BAD_POS;
				end else begin
					slot_a = shadow_head + pos - 4'd1;
					slot_b = shadow_head + pos;
					tmp = shadow_slots[slot_a];
					shadow_slots[slot_a] = shadow_slots[slot_b];
					shadow_slots[slot_b] = tmp;
				end
			end
			CMD_READ: begin
				if ({1'b0, pos} >= shadow_count)
					r.st = ST_BAD_POS;
				else
					r.rd = shadow_slots[shadow_head + pos];
			end
			CMD_CLEAR: begin
				shadow_count = '0;
				shadow_head = '0;
			end
			default: begin
			end
		endcase
		r.cnt = shadow_count;
		r.emp = (shadow_count == 0);
		return r;
	endfunction

	// Random idle gaps, with occasional stretches of none at all.
	task automatic draw_idle(inout int calm, output int cycles);
		if (calm > 0) begin
			calm--;
			cycles = 0;
		end else begin
			if ($urandom_range(0, 24) == 0)
				calm = $urandom_range(10, 40);
			cycles = $urandom_range(0, 4);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Driver: offers one pending command per beat and predicts it once accepted.
	always @(posedge clk or negedge arst_n) begin : command_driver
		queue_cmd_t next_cmd;
		int         gap;
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= '0;
			value <= '0;
			position <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(apply_command(command, value, position));
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					next_cmd = pending_cmds.pop_front();
					command <= next_cmd.cmd;
					value <= next_cmd.word;
					position <= next_cmd.pos;
					in_valid <= 1'b1;
					draw_idle(send_calm, gap);
					send_gap <= gap;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result beat against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		queue_result_t want;
		int            n;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual %h %h %h %h %h",
						$time, read_value, found_index, status, entry_count, is_empty);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("read_value", want.rd, read_value);
					check_field("found_index", 32'(want.idx), 32'(found_index));
					check_field("status", 32'(want.st), 32'(status));
					check_field("entry_count", 32'(want.cnt), 32'(entry_count));
					check_field("is_empty", 32'(want.emp), 32'(is_empty));
				end
				draw_idle(recv_calm, n);
				recv_wait = n;
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			out_stall <= hold_off || (recv_wait > 0);
		end
	end

	// One long hold-off on the result side so the queue backs up into its input.
	initial begin
		@(posedge arst_n);
		repeat (2500) @(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic add_cmd(input logic [2:0] cmd, input logic [31:0] word,
			input logic [3:0] pos);
		pending_cmds.push_back('{cmd: cmd, word: word, pos: pos});
	endtask

	function automatic logic [2:0] pick_command(int mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			0: begin
				if (r < 75) return CMD_PUSH;
				if (r < 85) return CMD_FIND;
				if (r < 92) return CMD_READ;
				return CMD_SWAP;
			end
			1: begin
				if (r < 55) return CMD_POP;
				if (r < 70) return CMD_FRONT;
				if (r < 80) return CMD_FIND;
				if (r < 90) return CMD_READ;
				return CMD_SWAP;
			end
			default: begin
				if (r < 20) return CMD_PUSH;
				if (r < 35) return CMD_POP;
				if (r < 45) return CMD_FRONT;
				if (r < 60) return CMD_FIND;
				if (r < 75) return CMD_SWAP;
				if (r < 90) return CMD_READ;
				if (r < 97) return CMD_CLEAR;
				return CMD_UNUSED;
			end
		endcase
	endfunction

	initial begin
		logic [31:0] pool [8];
		logic [31:0] word;
		logic [2:0]  cmd;
		int          mode;
		int          len;
		int          total;

		add_cmd(CMD_POP, 32'h0, 4'd0);
		add_cmd(CMD_FRONT, 32'h0, 4'd0);
		add_cmd(CMD_FIND, 32'h0, 4'd0);
		add_cmd(CMD_READ, 32'h0, 4'd0);
		add_cmd(CMD_SWAP, 32'h0, 4'd0);
		add_cmd(CMD_UNUSED, 32'hffff_ffff, 4'd15);
		add_cmd(CMD_PUSH, 32'h0, 4'd0);
		add_cmd(CMD_PUSH, 32'hffff_ffff, 4'd0);
		add_cmd(CMD_PUSH, 32'h5a5a_5a5a, 4'd0);
		add_cmd(CMD_FRONT, 32'h0, 4'd0);
		add_cmd(CMD_FIND, 32'hffff_ffff, 4'd0);
		add_cmd(CMD_FIND, 32'h1234_5678, 4'd0);
		add_cmd(CMD_SWAP, 32'h0, 4'd0);
		add_cmd(CMD_SWAP, 32'h0, 4'd1);
		add_cmd(CMD_SWAP, 32'h0, 4'd3);
		add_cmd(CMD_SWAP, 32'h0, 4'd2);
		add_cmd(CMD_READ, 32'h0, 4'd2);
		add_cmd(CMD_READ, 32'h0, 4'd15);
		add_cmd(CMD_POP, 32'h0, 4'd0);
		add_cmd(CMD_POP, 32'h0, 4'd0);
		add_cmd(CMD_CLEAR, 32'h0, 4'd0);
		add_cmd(CMD_POP, 32'h0, 4'd0);
		add_cmd(CMD_PUSH, 32'hffff_ffff, 4'd0);
		add_cmd(CMD_READ, 32'h0, 4'd0);

		// A small pool of repeated words gives find real hits.
		pool[0] = 32'h0;
		pool[1] = 32'hffff_ffff;
		for (int i = 2; i < 8; i++)
			pool[i] = $urandom;

		// Episodes of filling, draining, mixed traffic and the odd clear.
		total = 0;
		while (total < ITEM_TARGET) begin
			mode = $urandom_range(0, 9);
			if (mode == 9) begin
				add_cmd(CMD_CLEAR, $urandom, 4'($urandom_range(0, 15)));
				total++;
			end else begin
				len = $urandom_range(8, 24);
				for (int k = 0; k < len; k++) begin
					cmd = pick_command(mode <= 3 ? 0 : (mode <= 6 ? 1 : 2));
					case ($urandom_range(0, 3))
						0, 1: word = pool[3'($urandom_range(0, 7))];
						2: word = $urandom;
						default: word = $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
					endcase
					add_cmd(cmd, word, 4'($urandom_range(0, 15)));
					if (cmd != CMD_UNUSED)
						total++;
				end
			end
		end

		@(posedge arst_n);
		while (pending_cmds.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
